// File: sv/double_ended_queue_unit_macros.svh
// Assertion macros used by the deque unit RTL.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define DEQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication, checked on every rising edge outside reset.
`define DEQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/deq_pkg.sv
// Types, codes and default sizes shared by the deque unit.
`timescale 1ns / 1ps
package deq_pkg;

  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CountW       = 5;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_REPORT     = 3'd4;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [ValueW-1:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic [ValueW-1:0] front_value;
    logic [ValueW-1:0] back_value;
    logic [CountW-1:0] entry_count;
    logic              is_empty;
    status_e           status;
  } deq_out_t;

endpackage

// File: sv/double_ended_queue_unit.sv
// Top level of the double-ended queue unit.
//
// Usage: each input transaction carries a mode (push front, push back, pop
// front, pop back or report only) and a value used by pushes. Every input
// transaction yields exactly one output transaction with the front and back
// values, the entry count, an empty flag and a status code.
// Both channels use valid and stall; a transaction moves on a rising edge
// with valid high and stall low. Results leave from an output register.
// Pushes, reports, failed operations and a pop that empties the deque
// give their result in the cycle after acceptance, with the input open
// for the next one. A pop that leaves entries behind first reads the new
// end value from the registered read port of the entry memory and stalls
// the input meanwhile. The ends are otherwise served from registers.
// When the receiver stalls, the result is held and the input stalls until
// the output register is free again.
// Reset empties the deque at once; the entry memory is not cleared and
// needs no clearing pass.
`timescale 1ns / 1ps
module double_ended_queue_unit import deq_pkg::*; #(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  deq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output deq_out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [IdxW-1:0]       mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  deq_ctrl #(
    .Depth    (DEPTH),
    .DataWidth(DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  deq_ram #(
    .Depth    (DEPTH),
    .DataWidth(DATA_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

// File: sv/deq_ram.sv
// Entry store of the deque: one write port and one registered read port.
`timescale 1ns / 1ps
module deq_ram import deq_pkg::*; #(
  parameter int unsigned Depth     = DepthDef,
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataWidth-1:0]     wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataWidth-1:0]     rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/deq_ctrl.sv
// Deque control: ring indices, end-value cache, memory sequencing and result register.
`timescale 1ns / 1ps
`include "double_ended_queue_unit_macros.svh"
module deq_ctrl import deq_pkg::*; #(
  parameter int unsigned Depth     = DepthDef,
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  deq_in_t                  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output deq_out_t                 out_data_o,
  output logic                     mem_we_o,
  output logic [$clog2(Depth)-1:0] mem_waddr_o,
  output logic [DataWidth-1:0]     mem_wdata_o,
  output logic                     mem_re_o,
  output logic [$clog2(Depth)-1:0] mem_raddr_o,
  input  logic [DataWidth-1:0]     mem_rdata_i
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [CntW-1:0] OneCnt  = CntW'(1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] idx);
    return (idx == '0) ? LastIdx : idx - 1'b1;
  endfunction

  logic                 state_q, state_d;
  logic [IdxW-1:0]      front_idx_q, front_idx_d;
  logic [IdxW-1:0]      back_idx_q, back_idx_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [DataWidth-1:0] front_q, front_d;
  logic [DataWidth-1:0] back_q, back_d;
  logic                 pop_front_q, pop_front_d;
  logic                 out_valid_q, out_valid_d;
  deq_out_t             out_q, out_d;

  logic                 out_free;
  logic                 accept;
  logic                 load;
  logic [DataWidth-1:0] push_val;
  status_e              status;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_val   = DataWidth'(in_data_i.push_value);

  // The back index is kept as front plus count minus one, so it sits just
  // before the front index while the deque is empty.
  always_comb begin
    state_d     = state_q;
    front_idx_d = front_idx_q;
    back_idx_d  = back_idx_q;
    count_d     = count_q;
    front_d     = front_q;
    back_d      = back_q;
    pop_front_d = pop_front_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = front_idx_q;
    mem_wdata_o = push_val;
    mem_re_o    = 1'b0;
    mem_raddr_o = front_idx_q;
    status      = STATUS_OK;
    load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (in_data_i.mode)
            MODE_PUSH_FRONT: begin
              if (count_q == FullCnt) begin
                status = STATUS_FULL;
              end else begin
                front_idx_d = idx_dec(front_idx_q);
                mem_we_o    = 1'b1;
                mem_waddr_o = front_idx_d;
                front_d     = push_val;
                if (count_q == '0) begin
                  back_d = push_val;
                end
                count_d = count_q + 1'b1;
              end
            end
            MODE_PUSH_BACK: begin
              if (count_q == FullCnt) begin
                status = STATUS_FULL;
              end else begin
                back_idx_d  = idx_inc(back_idx_q);
                mem_we_o    = 1'b1;
                mem_waddr_o = back_idx_d;
                back_d      = push_val;
                if (count_q == '0) begin
                  front_d = push_val;
                end
                count_d = count_q + 1'b1;
              end
            end
            MODE_POP_FRONT: begin
              if (count_q == '0) begin
                status = STATUS_EMPTY;
              end else begin
                front_idx_d = idx_inc(front_idx_q);
                count_d     = count_q - 1'b1;
                // The new front value has to be fetched unless the deque drains.
                if (count_q != OneCnt) begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = front_idx_d;
                  pop_front_d = 1'b1;
                  state_d     = ST_READ;
                  load        = 1'b0;
                end
              end
            end
            MODE_POP_BACK: begin
              if (count_q == '0) begin
                status = STATUS_EMPTY;
              end else begin
                back_idx_d = idx_dec(back_idx_q);
                count_d    = count_q - 1'b1;
                if (count_q != OneCnt) begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = back_idx_d;
                  pop_front_d = 1'b0;
                  state_d     = ST_READ;
                  load        = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        load    = 1'b1;
        state_d = ST_IDLE;
        if (pop_front_q) begin
          front_d = mem_rdata_i;
        end else begin
          back_d = mem_rdata_i;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d.front_value = (count_d != '0) ? ValueW'(front_d) : '0;
    out_d.back_value  = (count_d != '0) ? ValueW'(back_d) : '0;
    out_d.entry_count = CountW'(count_d);
    out_d.is_empty    = (count_d == '0);
    out_d.status      = status;
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_idx_q <= '0;
      back_idx_q  <= LastIdx;
      count_q     <= '0;
      pop_front_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_idx_q <= front_idx_d;
      back_idx_q  <= back_idx_d;
      count_q     <= count_d;
      pop_front_q <= pop_front_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DEQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FullCnt, "entry count beyond depth")
  `DEQ_ASSERT(a_read_one_cycle, clk_i, rst_ni, (state_q == ST_READ) |=> (state_q == ST_IDLE), "read state held too long")
  `DEQ_ASSERT_IMP(a_read_quiet, clk_i, rst_ni, state_q == ST_READ, !mem_we_o && in_stall_o && !out_valid_q, "activity during read wait")
  `DEQ_ASSERT(a_read_result, clk_i, rst_ni, (state_q == ST_READ) |=> out_valid_q, "no result after read")

endmodule
